### hdl/fgs_pkg.sv
// ----------------------------------------------------------------------------
// fgs_pkg: shared types and constants for the FAT geometry selector
// Holds sequencer states, register indexes, band limits, size tiers and the
// request/response bundles of the serial divider.
// ----------------------------------------------------------------------------
package fgs_pkg;

    // Field widths fixed by the request and result formats
    localparam int KIND_W  = 2;
    localparam int DEV_W   = 32;
    localparam int CNT16_W = 16;
    localparam int SPC_W   = 8;
    localparam int OVH_W   = 17;
    localparam int EPS_W   = 9;
    localparam int LIM_W   = 28;
    localparam int COPY_W  = 2;
    localparam int DENOM_W = 17;
    localparam int DVD_W   = 33;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    // FAT variants
    localparam logic [KIND_W-1:0] KIND_FAT12 = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FAT16 = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAT32 = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

    // Cluster-count bands
    localparam logic [31:0] FAT12_BAND_END = 32'd4085;
    localparam logic [31:0] FAT16_BAND_END = 32'd65525;
    localparam logic [SPC_W-1:0] SWEEP_CEILING = 8'd128;

    // FAT32 starting tiers
    localparam logic [DEV_W-1:0] TIER_1  = 32'd532480;
    localparam logic [DEV_W-1:0] TIER_8  = 32'd16777216;
    localparam logic [DEV_W-1:0] TIER_16 = 32'd33554432;
    localparam logic [DEV_W-1:0] TIER_32 = 32'd67108864;

    // Register reset values
    localparam logic [EPS_W-1:0]  SMALL_EPS_RST = 9'd256;
    localparam logic [EPS_W-1:0]  WIDE_EPS_RST  = 9'd128;
    localparam logic [SPC_W-1:0]  LARGEST_RST   = 8'd128;
    localparam logic [LIM_W-1:0]  LIMIT_RST     = 28'd268435445;
    localparam logic [COPY_W-1:0] COPIES_RST    = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SMALL_EPS = 3'd0,
        REG_WIDE_EPS  = 3'd1,
        REG_LARGEST   = 3'd2,
        REG_LIMIT     = 3'd3,
        REG_COPIES    = 3'd4
    } fgs_reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_FAT_DIV,
        S_FAT_WAIT,
        S_SUB,
        S_CNT_WAIT,
        S_CHECK,
        S_EMIT
    } fgs_state_t;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DENOM_W-1:0] divisor;
    } fgs_div_req_t;

    typedef struct packed {
        logic             done;
        logic             busy;
        logic [DVD_W-1:0] quotient;
    } fgs_div_rsp_t;

endpackage

### hdl/fgs_div.sv
// ----------------------------------------------------------------------------
// fgs_div: serial restoring divider
// Produces one quotient bit per cycle; done pulses for one cycle at the end.
// ----------------------------------------------------------------------------
module fgs_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fgs_pkg::fgs_div_req_t req,
    output fgs_pkg::fgs_div_rsp_t rsp
);

    localparam int DVD_W   = fgs_pkg::DVD_W;
    localparam int DENOM_W = fgs_pkg::DENOM_W;
    localparam int CNT_W   = $clog2(DVD_W + 1);

    logic [DENOM_W-1:0] rem_reg,  rem_next;
    logic [DENOM_W-1:0] dsr_reg,  dsr_next;
    logic [DVD_W-1:0]   quo_reg,  quo_next;
    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DENOM_W:0]   trial_rem;
    logic               fits;

    assign trial_rem = {rem_reg, quo_reg[DVD_W-1]};
    assign fits      = trial_rem >= {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            dsr_next  = req.divisor;
            quo_next  = req.dividend;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit into the partial remainder
            if (fits)
                rem_next = DENOM_W'(trial_rem - {1'b0, dsr_reg});
            else
                rem_next = trial_rem[DENOM_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

endmodule

### hdl/fat_geometry_selector_top.sv
// ----------------------------------------------------------------------------
// fat_geometry_selector_top: FAT volume cluster size and FAT size selector
// Picks sectors per cluster, sectors per FAT copy and the data cluster count
// for a requested FAT variant and device size.
// ----------------------------------------------------------------------------
// Sequence: each trial cluster size takes up to two divisions on the shared
//   serial divider (FAT size, then cluster count) plus setup; up to eight trials.
// Throughput: one request at a time; s_tready stays low until the result is
//   placed in the output register, which then holds it until m_tready.
// Reset: rst_n is asynchronous, active low; it returns the sequencer to idle,
//   drops m_tvalid and loads the configuration registers with their defaults.
module fat_geometry_selector_top
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] device_sectors, [47:32] reserved_count, [63:48] root_dir_sectors,
    // [71:64] cluster_hint
    input  logic [71:0] s_tdata,
    // [1:0] fat_kind
    input  logic [1:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] cluster_sectors, [39:8] fat_sectors, [71:40] cluster_total
    output logic [71:0] m_tdata,
    // [0] status
    output logic [0:0]  m_tuser,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [27:0] cfg_data
);

    localparam int DEV_W   = fgs_pkg::DEV_W;
    localparam int SPC_W   = fgs_pkg::SPC_W;
    localparam int OVH_W   = fgs_pkg::OVH_W;
    localparam int DENOM_W = fgs_pkg::DENOM_W;
    localparam int DVD_W   = fgs_pkg::DVD_W;

    // ------------------------------------------------------------------
    // Configuration registers; writes are always taken
    // ------------------------------------------------------------------
    logic [fgs_pkg::EPS_W-1:0]  small_eps_reg;
    logic [fgs_pkg::EPS_W-1:0]  wide_eps_reg;
    logic [SPC_W-1:0]           largest_reg;
    logic [fgs_pkg::LIM_W-1:0]  limit_reg;
    logic [fgs_pkg::COPY_W-1:0] copies_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_eps_reg <= fgs_pkg::SMALL_EPS_RST;
            wide_eps_reg  <= fgs_pkg::WIDE_EPS_RST;
            largest_reg   <= fgs_pkg::LARGEST_RST;
            limit_reg     <= fgs_pkg::LIMIT_RST;
            copies_reg    <= fgs_pkg::COPIES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // indexes past the register list are dropped
            unique case (cfg_index)
                fgs_pkg::REG_SMALL_EPS: small_eps_reg <= cfg_data[fgs_pkg::EPS_W-1:0];
                fgs_pkg::REG_WIDE_EPS:  wide_eps_reg  <= cfg_data[fgs_pkg::EPS_W-1:0];
                fgs_pkg::REG_LARGEST:   largest_reg   <= cfg_data[SPC_W-1:0];
                fgs_pkg::REG_LIMIT:     limit_reg     <= cfg_data[fgs_pkg::LIM_W-1:0];
                fgs_pkg::REG_COPIES:    copies_reg    <= cfg_data[fgs_pkg::COPY_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request unpacking
    // ------------------------------------------------------------------
    logic [fgs_pkg::KIND_W-1:0]  in_kind;
    logic [DEV_W-1:0]            in_dev;
    logic [fgs_pkg::CNT16_W-1:0] in_resv;
    logic [fgs_pkg::CNT16_W-1:0] in_root;
    logic [SPC_W-1:0]            in_hint;
    logic [SPC_W-1:0]            tier_spc;

    assign in_kind = s_tuser;
    assign in_dev  = s_tdata[31:0];
    assign in_resv = s_tdata[47:32];
    assign in_root = s_tdata[63:48];
    assign in_hint = s_tdata[71:64];

    // FAT32 starting cluster size from the device size tiers
    always_comb
    begin
        priority if (in_dev <= fgs_pkg::TIER_1)
            tier_spc = 8'd1;
        else if (in_dev <= fgs_pkg::TIER_8)
            tier_spc = 8'd8;
        else if (in_dev <= fgs_pkg::TIER_16)
            tier_spc = 8'd16;
        else if (in_dev <= fgs_pkg::TIER_32)
            tier_spc = 8'd32;
        else
            tier_spc = 8'd64;
    end

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    fgs_pkg::fgs_state_t state_reg, state_next;

    logic [fgs_pkg::KIND_W-1:0] kind_reg,   kind_next;
    logic [DEV_W-1:0]           dev_reg,    dev_next;
    logic [OVH_W-1:0]           ovh_reg,    ovh_next;
    logic                       sweep_reg,  sweep_next;
    logic [SPC_W-1:0]           spc_reg,    spc_next;
    logic [DENOM_W-1:0]         denom_reg,  denom_next;
    logic [DEV_W-1:0]           avail_reg,  avail_next;
    logic [DEV_W-1:0]           fatsz_reg,  fatsz_next;
    logic [DEV_W-1:0]           count_reg,  count_next;
    logic                       ok_reg,     ok_next;

    logic                       m_valid_reg, m_valid_next;
    logic                       o_status_reg, o_status_next;
    logic [SPC_W-1:0]           o_spc_reg,    o_spc_next;
    logic [DEV_W-1:0]           o_fatsz_reg,  o_fatsz_next;
    logic [DEV_W-1:0]           o_count_reg,  o_count_next;

    fgs_pkg::fgs_div_req_t div_req;
    fgs_pkg::fgs_div_rsp_t div_rsp;

    logic [fgs_pkg::EPS_W-1:0] cap;
    logic [DEV_W+1:0]          fat_span;
    logic                      band_hit;
    logic                      out_free;

    assign cap = (kind_reg == fgs_pkg::KIND_FAT32) ? wide_eps_reg : small_eps_reg;
    assign fat_span = (DEV_W+2)'(copies_reg) * (DEV_W+2)'(fatsz_reg);
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        unique case (kind_reg)
            fgs_pkg::KIND_FAT12: band_hit = count_reg < fgs_pkg::FAT12_BAND_END;
            fgs_pkg::KIND_FAT16: band_hit = (count_reg >= fgs_pkg::FAT12_BAND_END)
                                         && (count_reg < fgs_pkg::FAT16_BAND_END);
            default:             band_hit = (count_reg >= fgs_pkg::FAT16_BAND_END)
                                         && (count_reg <= DEV_W'(limit_reg));
        endcase
    end

    assign s_tready = (state_reg == fgs_pkg::S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        dev_next      = dev_reg;
        ovh_next      = ovh_reg;
        sweep_next    = sweep_reg;
        spc_next      = spc_reg;
        denom_next    = denom_reg;
        avail_next    = avail_reg;
        fatsz_next    = fatsz_reg;
        count_next    = count_reg;
        ok_next       = ok_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        o_status_next = o_status_reg;
        o_spc_next    = o_spc_reg;
        o_fatsz_next  = o_fatsz_reg;
        o_count_next  = o_count_reg;
        div_req       = '0;

        unique case (state_reg)
            fgs_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next  = in_kind;
                    dev_next   = in_dev;
                    ovh_next   = OVH_W'(in_resv) + OVH_W'(in_root);
                    sweep_next = (in_hint == '0);
                    if (in_hint != '0)
                        spc_next = in_hint;
                    else if (in_kind == fgs_pkg::KIND_FAT32)
                        spc_next = tier_spc;
                    else
                        spc_next = 8'd1;
                    ok_next    = 1'b0;
                    if (in_kind == fgs_pkg::KIND_BAD)
                        state_next = fgs_pkg::S_EMIT;
                    else
                        state_next = fgs_pkg::S_PREP;
                end
            end

            fgs_pkg::S_PREP:
            begin
                // divisor for the FAT size: entries per sector times cluster size, plus the FAT copy count
                denom_next = DENOM_W'(cap) * DENOM_W'(spc_reg) + DENOM_W'(copies_reg);
                avail_next = dev_reg - DEV_W'(ovh_reg);
                if (dev_reg <= DEV_W'(ovh_reg))
                begin
                    fatsz_next = '0;
                    count_next = '0;
                    state_next = fgs_pkg::S_CHECK;
                end
                else
                    state_next = fgs_pkg::S_FAT_DIV;
            end

            fgs_pkg::S_FAT_DIV:
            begin
                if (denom_reg == '0)
                begin
                    fatsz_next = '0;
                    state_next = fgs_pkg::S_SUB;
                end
                else
                begin
                    // round up: (avail + denom - 1) / denom
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(avail_reg) + DVD_W'(denom_reg) - DVD_W'(1);
                    div_req.divisor  = denom_reg;
                    state_next       = fgs_pkg::S_FAT_WAIT;
                end
            end

            fgs_pkg::S_FAT_WAIT:
            begin
                if (div_rsp.done)
                begin
                    fatsz_next = div_rsp.quotient[DEV_W-1:0];
                    state_next = fgs_pkg::S_SUB;
                end
            end

            fgs_pkg::S_SUB:
            begin
                if ({2'b00, avail_reg} <= fat_span)
                begin
                    count_next = '0;
                    state_next = fgs_pkg::S_CHECK;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(avail_reg - fat_span[DEV_W-1:0]);
                    div_req.divisor  = DENOM_W'(spc_reg);
                    state_next       = fgs_pkg::S_CNT_WAIT;
                end
            end

            fgs_pkg::S_CNT_WAIT:
            begin
                if (div_rsp.done)
                begin
                    count_next = div_rsp.quotient[DEV_W-1:0];
                    state_next = fgs_pkg::S_CHECK;
                end
            end

            fgs_pkg::S_CHECK:
            begin
                priority if (band_hit)
                begin
                    ok_next    = 1'b1;
                    state_next = fgs_pkg::S_EMIT;
                end
                else if (!sweep_reg || (spc_reg >= largest_reg)
                         || (spc_reg >= fgs_pkg::SWEEP_CEILING))
                begin
                    ok_next    = 1'b0;
                    state_next = fgs_pkg::S_EMIT;
                end
                else
                begin
                    // double the cluster size and retry
                    spc_next   = {spc_reg[SPC_W-2:0], 1'b0};
                    state_next = fgs_pkg::S_PREP;
                end
            end

            fgs_pkg::S_EMIT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    o_status_next = !ok_reg;
                    o_spc_next    = ok_reg ? spc_reg   : '0;
                    o_fatsz_next  = ok_reg ? fatsz_reg : '0;
                    o_count_next  = ok_reg ? count_reg : '0;
                    state_next    = fgs_pkg::S_IDLE;
                end
            end

            default:
                state_next = fgs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fgs_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        dev_reg      <= dev_next;
        ovh_reg      <= ovh_next;
        sweep_reg    <= sweep_next;
        spc_reg      <= spc_next;
        denom_reg    <= denom_next;
        avail_reg    <= avail_next;
        fatsz_reg    <= fatsz_next;
        count_reg    <= count_next;
        ok_reg       <= ok_next;
        o_status_reg <= o_status_next;
        o_spc_reg    <= o_spc_next;
        o_fatsz_reg  <= o_fatsz_next;
        o_count_reg  <= o_count_next;
    end

    // Shared serial divider: FAT size first, then the cluster count
    fgs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {o_count_reg, o_fatsz_reg, o_spc_reg};
    assign m_tuser[0] = o_status_reg;

`ifndef ASSERT_OFF
    // an accepted request blocks the input for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // a failed result carries zero fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("failed result with nonzero fields");

    // a good result always has a nonzero cluster size
    a_ok_spc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] != '0)
        else $error("good result with zero cluster size");

    // the divider is only started while it is idle
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");
`endif

endmodule

### bench/tb_fat_geometry_selector_top.sv
// ----------------------------------------------------------------------------
// tb_fat_geometry_selector_top: self-checking bench for the FAT geometry selector
// Drives format requests on the request stream and checks every result
// against a typed expectation or a bench model of the cluster-size sweep. The
// run walks several register settings (extremes among them) and several sender
// and receiver idling phases.
// ----------------------------------------------------------------------------
module tb_fat_geometry_selector_top;

    // Result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_SIZE = 1'b1;

    // Short names for the FAT variants used in the stimulus table
    localparam logic [fgs_pkg::KIND_W-1:0] KIND_FAT12 = fgs_pkg::KIND_FAT12;
    localparam logic [fgs_pkg::KIND_W-1:0] KIND_FAT16 = fgs_pkg::KIND_FAT16;
    localparam logic [fgs_pkg::KIND_W-1:0] KIND_FAT32 = fgs_pkg::KIND_FAT32;
    localparam logic [fgs_pkg::KIND_W-1:0] KIND_BAD   = fgs_pkg::KIND_BAD;

    // Cycles with no transfer on any channel before the run is declared hung.
    localparam int QUIET_LIMIT = 20000;
    localparam int TAIL_CYCLES = 600;
    localparam int PHASE_ITEMS = 220;

    typedef struct packed {
        logic [fgs_pkg::KIND_W-1:0]  kind;
        logic [fgs_pkg::DEV_W-1:0]   dev;
        logic [fgs_pkg::CNT16_W-1:0] resv;
        logic [fgs_pkg::CNT16_W-1:0] root;
        logic [fgs_pkg::SPC_W-1:0]   hint;
    } request_t;

    typedef struct packed {
        logic                      status;
        logic [fgs_pkg::SPC_W-1:0] cluster_sectors;
        logic [31:0]               fat_sectors;
        logic [31:0]               cluster_total;
    } geometry_t;

    typedef struct packed {
        request_t  req;
        logic      typed;
        geometry_t want;
    } directed_row_t;

    localparam geometry_t GEOM_NONE  = '0;
    localparam geometry_t GEOM_FAIL  = '{STATUS_BAD_SIZE, 8'd0, 32'd0, 32'd0};
    localparam geometry_t GEOM_EMPTY = '{STATUS_OK, 8'd1, 32'd0, 32'd0};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [27:0] cfg_data  = '0;

    fat_geometry_selector_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Bench copy of the configuration registers, loaded with reset values
    logic [fgs_pkg::EPS_W-1:0]  eps_small   = fgs_pkg::SMALL_EPS_RST;
    logic [fgs_pkg::EPS_W-1:0]  eps_wide    = fgs_pkg::WIDE_EPS_RST;
    logic [fgs_pkg::SPC_W-1:0]  largest_spc = fgs_pkg::LARGEST_RST;
    logic [fgs_pkg::LIM_W-1:0]  wide_limit  = fgs_pkg::LIMIT_RST;
    logic [fgs_pkg::COPY_W-1:0] copies      = fgs_pkg::COPIES_RST;

    geometry_t pending_geometry[$];
    int        error_count      = 0;
    int        sender_idle_pct  = 0;
    int        stall_pct        = 0;
    int        quiet_cycles     = 0;

    // Directed requests, all under reset configuration. Rows with a typed
    // result are readable at a glance; the rest go through the model.
    directed_row_t directed_rows [25] = '{
        // unknown variant always fails, with or without a hint
        '{'{KIND_BAD,   32'd1000000,    16'd32,    16'd0,     8'd0},   1'b1, GEOM_FAIL},
        '{'{KIND_BAD,   32'd1000000,    16'd32,    16'd0,     8'd8},   1'b1, GEOM_FAIL},
        // device no larger than overhead: FAT12 succeeds with zero FAT size and count
        '{'{KIND_FAT12, 32'd0,          16'd0,     16'd0,     8'd0},   1'b1, GEOM_EMPTY},
        '{'{KIND_FAT12, 32'd100,        16'd64,    16'd36,    8'd0},   1'b1, GEOM_EMPTY},
        // one free sector: the FAT copies eat it, count is zero
        '{'{KIND_FAT12, 32'd1,          16'd0,     16'd0,     8'd0},   1'b1,
          '{STATUS_OK, 8'd1, 32'd1, 32'd0}},
        // zero count never fits the FAT16 or FAT32 band
        '{'{KIND_FAT16, 32'd0,          16'd0,     16'd0,     8'd0},   1'b1, GEOM_FAIL},
        '{'{KIND_FAT32, 32'd0,          16'd0,     16'd0,     8'd0},   1'b1, GEOM_FAIL},
        // sweep runs out at the largest cluster size; the next rows find a fit in the band
        '{'{KIND_FAT12, 32'hFFFF_FFFF,  16'd0,     16'd0,     8'd0},   1'b1, GEOM_FAIL},
        '{'{KIND_FAT12, 32'd4000,       16'd1,     16'd32,    8'd0},   1'b0, GEOM_NONE},
        '{'{KIND_FAT16, 32'd70000,      16'd1,     16'd32,    8'd0},   1'b0, GEOM_NONE},
        '{'{KIND_FAT16, 32'd2000000,    16'd4,     16'd32,    8'd0},   1'b0, GEOM_NONE},
        // FAT32 starting tiers, on each boundary and just past all but TIER_16
        '{'{KIND_FAT32, 32'd532480,     16'd32,    16'd0,     8'd0},   1'b0, GEOM_NONE},
        '{'{KIND_FAT32, 32'd532481,     16'd32,    16'd0,     8'd0},   1'b0, GEOM_NONE},
        '{'{KIND_FAT32, 32'd16777216,   16'd32,    16'd0,     8'd0},   1'b0, GEOM_NONE},
        '{'{KIND_FAT32, 32'd16777217,   16'd32,    16'd0,     8'd0},   1'b0, GEOM_NONE},
        '{'{KIND_FAT32, 32'd33554432,   16'd32,    16'd0,     8'd0},   1'b0, GEOM_NONE},
        '{'{KIND_FAT32, 32'd67108864,   16'd32,    16'd0,     8'd0},   1'b0, GEOM_NONE},
        '{'{KIND_FAT32, 32'd67108865,   16'd32,    16'd0,     8'd0},   1'b0, GEOM_NONE},
        // field extremes
        '{'{KIND_FAT32, 32'hFFFF_FFFF,  16'hFFFF,  16'hFFFF,  8'd0},   1'b0, GEOM_NONE},
        '{'{KIND_FAT16, 32'hFFFF_FFFF,  16'hFFFF,  16'hFFFF,  8'hFF},  1'b0, GEOM_NONE},
        // hints: odd value, largest power of two, one sector; the first two miss the band
        '{'{KIND_FAT12, 32'd20000,      16'd1,     16'd32,    8'd3},   1'b0, GEOM_NONE},
        '{'{KIND_FAT16, 32'd500000,     16'd4,     16'd32,    8'd128}, 1'b0, GEOM_NONE},
        '{'{KIND_FAT32, 32'd8000000,    16'd32,    16'd0,     8'd1},   1'b0, GEOM_NONE},
        // near the FAT12 / FAT16 band edge
        '{'{KIND_FAT12, 32'd12000,      16'd0,     16'd0,     8'd0},   1'b0, GEOM_NONE},
        '{'{KIND_FAT16, 32'd4200,       16'd0,     16'd0,     8'd0},   1'b0, GEOM_NONE}
    };

    // 20-unit clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Compute the geometry the block must return for one request under the
    // current bench copy of the registers.
    function automatic geometry_t predict_geometry(request_t r);
        geometry_t       res;
        longint unsigned eps;
        longint unsigned overhead;
        longint unsigned avail;
        longint unsigned denom;
        longint unsigned fat_len;
        longint unsigned fat_span;
        longint unsigned clusters;
        longint unsigned spc;
        logic            sweep;
        logic            fits;
        res = GEOM_FAIL;
        if (r.kind == KIND_BAD)
            return res;
        eps      = (r.kind == KIND_FAT32) ? eps_wide : eps_small;
        overhead = r.resv;
        overhead = overhead + r.root;
        sweep    = (r.hint == 0);
        if (!sweep)
            spc = r.hint;
        else if (r.kind != KIND_FAT32)
            spc = 1;
        else if (r.dev <= fgs_pkg::TIER_1)
            spc = 1;
        else if (r.dev <= fgs_pkg::TIER_8)
            spc = 8;
        else if (r.dev <= fgs_pkg::TIER_16)
            spc = 16;
        else if (r.dev <= fgs_pkg::TIER_32)
            spc = 32;
        else
            spc = 64;
        for (int trial_no = 0; trial_no < 10; trial_no++)
        begin
            if (r.dev <= overhead)
            begin
                fat_len  = 0;
                clusters = 0;
            end
            else
            begin
                avail    = r.dev - overhead;
                denom    = eps * spc + copies;
                fat_len  = (denom == 0) ? 0 : (avail + denom - 1) / denom;
                fat_span = copies * fat_len;
                clusters = (avail <= fat_span) ? 0 : (avail - fat_span) / spc;
            end
            case (r.kind)
                KIND_FAT12: fits = (clusters < fgs_pkg::FAT12_BAND_END);
                KIND_FAT16: fits = (clusters >= fgs_pkg::FAT12_BAND_END)
                                   && (clusters < fgs_pkg::FAT16_BAND_END);
                default:    fits = (clusters >= fgs_pkg::FAT16_BAND_END)
                                   && (clusters <= wide_limit);
            endcase
            if (fits)
            begin
                res.status          = STATUS_OK;
                res.cluster_sectors = spc[fgs_pkg::SPC_W-1:0];
                res.fat_sectors     = fat_len[31:0];
                res.cluster_total   = clusters[31:0];
                return res;
            end
            if (!sweep || spc >= largest_spc || spc >= fgs_pkg::SWEEP_CEILING)
                return res;
            spc = spc * 2;
        end
        return res;
    endfunction

    // Random request: mostly sized so that the sweep lands in or near the
    // variant's band, the rest raw noise over every field.
    function automatic request_t make_request();
        request_t r;
        int       pick;
        int       shift;
        int       e;
        r = '0;
        if ($urandom_range(99) < 12)
        begin
            r.kind = 2'($urandom_range(3));
            r.dev  = $urandom;
            r.resv = 16'($urandom);
            r.root = 16'($urandom);
            r.hint = 8'($urandom);
            return r;
        end
        pick = $urandom_range(99);
        if (pick < 28)
            r.kind = KIND_FAT12;
        else if (pick < 58)
            r.kind = KIND_FAT16;
        else if (pick < 95)
            r.kind = KIND_FAT32;
        else
            r.kind = KIND_BAD;
        shift = $urandom_range(7);
        case (r.kind)
            KIND_FAT12: r.dev = $urandom_range(32'd4300 << shift);
            KIND_FAT16: r.dev = $urandom_range(32'd66000 << shift, 32'd4000 << shift);
            default:
            begin
                e     = $urandom_range(31, 16);
                r.dev = (32'd1 << e) | ($urandom & ((32'd1 << e) - 32'd1));
            end
        endcase
        if ($urandom_range(99) < 90)
            r.resv = 16'($urandom_range(64, 1));
        else
            r.resv = 16'($urandom);
        pick = $urandom_range(99);
        if (r.kind == KIND_FAT32 && pick < 85)
            r.root = '0;
        else if (pick < 93)
            r.root = 16'($urandom_range(64));
        else
            r.root = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)
            r.hint = '0;
        else if (pick < 93)
            r.hint = 8'd1 << $urandom_range(7);
        else
            r.hint = 8'($urandom_range(255, 1));
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Offer one request, holding random gaps first; tvalid stays high after
    // the transfer so back-to-back requests never see a lowered valid.
    task automatic send_request(request_t r, logic typed, geometry_t want);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.hint, r.root, r.resv, r.dev};
        s_tuser  <= r.kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_geometry.push_back(typed ? want : predict_geometry(r));
    endtask

    // Hold until every pending result has come back
    task automatic drain_results();
        while (pending_geometry.size() != 0)
            @(posedge clk);
    endtask

    // One register transfer; the caller drops cfg_valid after the last one
    task automatic write_register(fgs_pkg::fgs_reg_idx_t idx, logic [27:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            fgs_pkg::REG_SMALL_EPS: eps_small   = value[fgs_pkg::EPS_W-1:0];
            fgs_pkg::REG_WIDE_EPS:  eps_wide    = value[fgs_pkg::EPS_W-1:0];
            fgs_pkg::REG_LARGEST:   largest_spc = value[fgs_pkg::SPC_W-1:0];
            fgs_pkg::REG_LIMIT:     wide_limit  = value[fgs_pkg::LIM_W-1:0];
            fgs_pkg::REG_COPIES:    copies      = value[fgs_pkg::COPY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(int small_eps, int wide_eps, int largest, int limit,
                                  int fat_copy_count);
        write_register(fgs_pkg::REG_SMALL_EPS, 28'(small_eps));
        write_register(fgs_pkg::REG_WIDE_EPS, 28'(wide_eps));
        write_register(fgs_pkg::REG_LARGEST, 28'(largest));
        write_register(fgs_pkg::REG_LIMIT, 28'(limit));
        write_register(fgs_pkg::REG_COPIES, 28'(fat_copy_count));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(int items, int send_idle, int recv_stall);
        sender_idle_pct = send_idle;
        stall_pct       = recv_stall;
        repeat (items)
            send_request(make_request(), 1'b0, GEOM_NONE);
        s_tvalid <= 1'b0;
        drain_results();
    endtask

    // Receiver side: random backpressure at the current stall rate
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Result checker: compare each result transfer with the oldest pending one
    always @(posedge clk)
    begin
        geometry_t got;
        geometry_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status          = m_tuser[0];
            got.cluster_sectors = m_tdata[7:0];
            got.fat_sectors     = m_tdata[39:8];
            got.cluster_total   = m_tdata[71:40];
            if (pending_geometry.size() == 0)
                report_mismatch($sformatf("result with nothing pending: %h", got));
            else
            begin
                want = pending_geometry.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              got.status, want.status));
                if (got.cluster_sectors !== want.cluster_sectors)
                    report_mismatch($sformatf("cluster_sectors %0d, want %0d",
                                              got.cluster_sectors, want.cluster_sectors));
                if (got.fat_sectors !== want.fat_sectors)
                    report_mismatch($sformatf("fat_sectors %0d, want %0d",
                                              got.fat_sectors, want.fat_sectors));
                if (got.cluster_total !== want.cluster_total)
                    report_mismatch($sformatf("cluster_total %0d, want %0d",
                                              got.cluster_total, want.cluster_total));
            end
        end
    end

    // Watchdog: count cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass under reset values, no idling on either side
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        s_tvalid <= 1'b0;
        drain_results();

        // Widest entries, single FAT copy; sender mostly idle
        apply_settings(256, 256, 128, 268435445, 1);
        run_random_phase(PHASE_ITEMS, 88, 0);

        // Narrowest entries, no doubling past the starting cluster size, lowest FAT32 cap;
        // receiver mostly stalling
        apply_settings(1, 1, 1, 65525, 2);
        run_random_phase(PHASE_ITEMS, 0, 88);

        // Mid values, both sides idling
        apply_settings(128, 64, 64, 1000000, 2);
        run_random_phase(PHASE_ITEMS, 37, 37);

        // Random in-range setting, no idling
        apply_settings($urandom_range(256, 1), $urandom_range(256, 1),
                       $urandom_range(128, 1), $urandom_range(268435445, 65525),
                       $urandom_range(2, 1));
        run_random_phase(PHASE_ITEMS, 0, 0);

        // Zero entries per sector with no FAT copies: every FAT size divisor is zero
        apply_settings(0, 0, 128, 268435445, 0);
        run_random_phase(100, 0, 0);

        // Let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
hdl/fgs_pkg.sv
hdl/fgs_div.sv
hdl/fat_geometry_selector_top.sv
bench/tb_fat_geometry_selector_top.sv
